// ===== hdl/ordered_list_shift_store_top_macros.svh =====
// assertion macros for the ordered list shift store checker
`ifndef ORDERED_LIST_SHIFT_STORE_TOP_MACROS_SVH
`define ORDERED_LIST_SHIFT_STORE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define OL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// next-cycle implication, disabled during reset
`define OL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

// ===== hdl/ols_pkg.sv =====
// shared types and constants for the ordered list shift store
`default_nettype none
package ols_pkg;

    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_GET    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what every cell does in the cycle of a transfer
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } ols_in_t;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_full;
        logic                 is_empty;
    } ols_out_t;

    // command broadcast from the control to the cell row
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] item;
    } ols_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/ordered_list_shift_store_top.sv =====
// top level of the ordered list shift store: control, cell row, result register
// The list holds up to CAPACITY words in a row of cells; push, pop, insert,
// remove and get each take one transfer, because every
// cell loads its new word (the item, its lower or its upper neighbor) in the
// same edge, so a new item is taken every cycle while the output is not stalled. The result appears in the
// output register in the cycle after the input transfer and a new input is taken
// while a waiting result is consumed in the same cycle. Cell words are only
// defined below the count; get reads through a one-hot OR over the cells.
`default_nettype none
module ordered_list_shift_store_top #(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ols_pkg::ols_in_t s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ols_pkg::ols_out_t     m_item
);
    import ols_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DW    = (ITEM_BITS < VAL_W) ? ITEM_BITS : VAL_W;
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0]    CAP_CNT = CW'(CAPACITY);
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    ols_out_t      out_reg;
    ols_out_t      out_next;

    ols_cmd_t      cmd;
    logic          in_xfer;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic          full;
    logic [DW-1:0] cell_data [CAPACITY];
    logic [DW-1:0] cell_tap  [CAPACITY];
    logic [DW-1:0] rd_or;
    status_t       status;
    cell_op_t      op;
    logic [VAL_W-1:0] rd_value;

    assign in_xfer = s_valid && s_ready;
    assign s_ready = !out_valid_reg || m_ready;
    assign pos_ext = CMP_W'(s_item.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CAP_CNT);

    // read bus: one-hot OR over the cell taps
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_tap[i];
        end
    end

    // operation decode, status and new count
    always_comb begin
        op         = CELL_HOLD;
        status     = ST_OK;
        count_next = count_reg;
        rd_value   = '0;
        case (s_item.action)
            ACT_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op         = CELL_PUSH;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP: begin
                if (count_reg != '0) count_next = count_reg - 1'b1;
            end
            ACT_INSERT: begin
                if (pos_ext > cnt_ext || pos_ext >= CAP_CMP) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    op         = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    op         = CELL_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_GET: begin
                if (pos_ext >= cnt_ext) status = ST_RANGE;
                else rd_value = VAL_W'(rd_or);
            end
            default: begin
                op = CELL_HOLD;
            end
        endcase
    end

    // command to the cells, held unless a transfer happens
    always_comb begin
        cmd.op   = in_xfer ? op : CELL_HOLD;
        cmd.pos  = s_item.position;
        cmd.item = s_item.item_value;
    end

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ols_cell #(
            .INDEX (g),
            .CW    (CW),
            .DW    (DW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .lower_data (cell_data[(g == 0) ? 0 : g - 1]),
            .upper_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .data       (cell_data[g]),
            .rd_tap     (cell_tap[g])
        );
    end

    // result word
    always_comb begin
        out_next.read_value  = rd_value;
        out_next.status      = status;
        out_next.entry_count = CNT_OUT_W'(count_next);
        out_next.is_full     = (count_next == CAP_CNT);
        out_next.is_empty    = (count_next == '0);
    end

    // output valid follows transfers on both sides
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_xfer) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_xfer) count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule
`default_nettype wire

// ===== hdl/ols_cell.sv =====
// one storage cell of the list, loads the item or takes a neighbor's word
`default_nettype none
module ols_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7,
    parameter int DW    = 32
) (
    input  wire logic              aclk,
    input  wire ols_pkg::ols_cmd_t cmd,
    input  wire logic [CW-1:0]     count,
    input  wire logic [DW-1:0]     lower_data,
    input  wire logic [DW-1:0]     upper_data,
    output logic      [DW-1:0]     data,
    output logic      [DW-1:0]     rd_tap
);
    import ols_pkg::*;

    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DW-1:0]    data_reg;
    logic [DW-1:0]    data_next;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign pos_ext = CMP_W'(cmd.pos);
    assign cnt_ext = CMP_W'(count);

    // next word of this cell
    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CELL_PUSH: begin
                if (IDX == cnt_ext) data_next = DW'(cmd.item);
            end
            CELL_INSERT: begin
                if (IDX == pos_ext) data_next = DW'(cmd.item);
                else if (IDX > pos_ext) data_next = lower_data;
            end
            CELL_REMOVE: begin
                if (IDX >= pos_ext) data_next = upper_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // word presented on the read bus when this cell is addressed
    assign data   = data_reg;
    assign rd_tap = (IDX == pos_ext) ? data_reg : '0;

endmodule
`default_nettype wire

// ===== hdl/ols_checker.sv =====
// port-level checker for the ordered list shift store, bound to the top level
`default_nettype none
`include "ordered_list_shift_store_top_macros.svh"
module ols_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire ols_pkg::ols_in_t  s_item,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire ols_pkg::ols_out_t m_item
);
    import ols_pkg::*;

    // a stalled result holds
    `OL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item))
    // an input transfer into an empty output register gives a result next
    `OL_ASSERT_NEXT(a_result_follows, s_valid && s_ready && !m_valid, m_valid)
    // a full report comes only while the list is full
    `OL_ASSERT_NOW(a_full_status, m_valid && m_item.status == ST_FULL, m_item.is_full)
    // a nonzero read value only with ok status, and never full and empty at once
    `OL_ASSERT_NOW(a_read_ok, m_valid && m_item.read_value != '0,
                   m_item.status == ST_OK && !(m_item.is_full && m_item.is_empty))

endmodule

bind ordered_list_shift_store_top ols_checker u_ols_checker (.*);
`default_nettype wire

// ===== tb/sv/ordered_list_shift_store_tb.sv =====
// self-checking testbench for the ordered list shift store, directed table then random traffic
`timescale 1ns / 100ps
module testbench;
    import ols_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int DIRECTED_ROWS  = 25;
    localparam int PHASE_ITEMS    = 350;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;

    // action codes the block leaves unused
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef enum int {
        TREND_GROW,
        TREND_MIXED,
        TREND_SHRINK
    } trend_t;

    typedef struct {
        ols_in_t  req;
        bit       typed;
        ols_out_t want;
    } dir_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ols_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    ols_out_t m_item;

    // shadow copy of the list
    logic [VAL_W-1:0] list_words [LIST_DEPTH];
    int               list_fill;

    ols_out_t due_answers[$];
    ols_out_t want_rsp;
    ols_out_t pred_rsp;
    dir_row_t dir_rows[DIRECTED_ROWS];

    bit       cur_typed_en;
    ols_out_t cur_typed;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatch_count;
    int       quiet_cycles;
    int       act_seen [8];
    int       full_answers;
    int       empty_answers;
    int       range_answers;
    int       full_rejects;

    ordered_list_shift_store_top #(
        .CAPACITY (LIST_DEPTH),
        .ITEM_BITS(VAL_W)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // answer of one list operation, updates the shadow list
    function automatic ols_out_t predict_list_op(ols_in_t req);
        ols_out_t rsp;
        int       pos;
        rsp = '0;
        pos = int'(req.position);
        rsp.status = ST_OK;
        case (req.action)
            ACT_PUSH: begin
                if (list_fill >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_words[list_fill] = req.item_value;
                    list_fill++;
                end
            end
            ACT_POP: begin
                if (list_fill > 0) list_fill--;
            end
            ACT_INSERT: begin
                // range check wins over the full check
                if (pos > list_fill || pos >= LIST_DEPTH) begin
                    rsp.status = ST_RANGE;
                end else if (list_fill >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = list_fill; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = req.item_value;
                    list_fill++;
                end
            end
            ACT_REMOVE: begin
                if (pos >= list_fill) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
                    list_fill--;
                end
            end
            ACT_GET: begin
                if (pos >= list_fill) rsp.status = ST_RANGE;
                else rsp.read_value = list_words[pos];
            end
            default: begin
            end
        endcase
        rsp.entry_count = CNT_OUT_W'(list_fill);
        rsp.is_full     = (list_fill == LIST_DEPTH);
        rsp.is_empty    = (list_fill == 0);
        return rsp;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(ols_in_t req);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // prediction on input transfers, checking on result transfers, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready) begin
                pred_rsp = predict_list_op(s_item);
                act_seen[s_item.action]++;
                if (pred_rsp.is_full) full_answers++;
                if (pred_rsp.is_empty) empty_answers++;
                if (pred_rsp.status == ST_RANGE) range_answers++;
                if (pred_rsp.status == ST_FULL) full_rejects++;
                due_answers.push_back(cur_typed_en ? cur_typed : pred_rsp);
            end
            if (m_valid && m_ready) begin
                if (due_answers.size() == 0) begin
                    report_mismatch("result with nothing due", m_item.read_value, '0);
                end else begin
                    want_rsp = due_answers.pop_front();
                    check_field("read_value", m_item.read_value, want_rsp.read_value);
                    check_field("status", 32'(m_item.status), 32'(want_rsp.status));
                    check_field("entry_count", 32'(m_item.entry_count),
                                32'(want_rsp.entry_count));
                    check_field("is_full", 32'(m_item.is_full), 32'(want_rsp.is_full));
                    check_field("is_empty", 32'(m_item.is_empty), 32'(want_rsp.is_empty));
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("ordered_list_shift_store_top regression: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        ols_out_t   empty_ok;
        ols_out_t   empty_range;
        ols_in_t    req;
        trend_t     trend;
        int         burst_left;
        int         r;
        int         pos_pick;

        s_valid        = 1'b0;
        s_item         = '0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        cur_typed_en   = 1'b0;
        cur_typed      = '0;
        send_idle_pct  = 36;
        recv_idle_pct  = 50;
        mismatch_count = 0;
        quiet_cycles   = 0;
        list_fill      = 0;
        full_answers   = 0;
        empty_answers  = 0;
        range_answers  = 0;
        full_rejects   = 0;
        foreach (act_seen[i]) act_seen[i] = 0;
        foreach (list_words[i]) list_words[i] = '0;

        // answers on the empty list right after reset
        empty_ok             = '0;
        empty_ok.status      = ST_OK;
        empty_ok.is_empty    = 1'b1;
        empty_range          = empty_ok;
        empty_range.status   = ST_RANGE;

        // directed table: empty-list corner cases typed in, the rest predicted
        dir_rows[0]  = '{'{ACT_POP,    6'd0,  32'h0},        1'b1, empty_ok};
        dir_rows[1]  = '{'{ACT_GET,    6'd0,  32'h0},        1'b1, empty_range};
        dir_rows[2]  = '{'{ACT_REMOVE, 6'd0,  32'h0},        1'b1, empty_range};
        dir_rows[3]  = '{'{ACT_INSERT, 6'd1,  32'hFFFFFFFF}, 1'b1, empty_range};
        dir_rows[4]  = '{'{ACT_INSERT, 6'd63, 32'h0},        1'b1, empty_range};
        dir_rows[5]  = '{'{ACT_GET,    6'd63, 32'h0},        1'b1, empty_range};
        dir_rows[6]  = '{'{ACT_SPARE_LO, 6'd63, 32'hFFFFFFFF}, 1'b1, empty_ok};
        dir_rows[7]  = '{'{ACT_SPARE_HI, 6'd0,  32'h0},        1'b1, empty_ok};
        dir_rows[8]  = '{'{ACT_PUSH,   6'd63, 32'hFFFFFFFF}, 1'b0, '0};
        dir_rows[9]  = '{'{ACT_PUSH,   6'd0,  32'h0},        1'b0, '0};
        dir_rows[10] = '{'{ACT_INSERT, 6'd0,  32'hA5A5A5A5}, 1'b0, '0};
        // insert at the count appends
        dir_rows[11] = '{'{ACT_INSERT, 6'd3,  32'h5A5A5A5A}, 1'b0, '0};
        dir_rows[12] = '{'{ACT_INSERT, 6'd1,  32'h12345678}, 1'b0, '0};
        dir_rows[13] = '{'{ACT_GET,    6'd0,  32'h0},        1'b0, '0};
        dir_rows[14] = '{'{ACT_GET,    6'd4,  32'h0},        1'b0, '0};
        dir_rows[15] = '{'{ACT_GET,    6'd5,  32'h0},        1'b0, '0};
        dir_rows[16] = '{'{ACT_INSERT, 6'd7,  32'h0},        1'b0, '0};
        dir_rows[17] = '{'{ACT_REMOVE, 6'd0,  32'h0},        1'b0, '0};
        dir_rows[18] = '{'{ACT_REMOVE, 6'd3,  32'h0},        1'b0, '0};
        dir_rows[19] = '{'{ACT_REMOVE, 6'd1,  32'h0},        1'b0, '0};
        dir_rows[20] = '{'{ACT_GET,    6'd1,  32'h0},        1'b0, '0};
        dir_rows[21] = '{'{ACT_SPARE_MID, 6'd21, 32'hC3C3C3C3}, 1'b0, '0};
        dir_rows[22] = '{'{ACT_POP,    6'd0,  32'h0},        1'b0, '0};
        dir_rows[23] = '{'{ACT_GET,    6'd1,  32'h0},        1'b0, '0};
        dir_rows[24] = '{'{ACT_POP,    6'd0,  32'h0},        1'b0, '0};

        // reset
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        foreach (dir_rows[i]) begin
            cur_typed_en = dir_rows[i].typed;
            cur_typed    = dir_rows[i].want;
            send_item(dir_rows[i].req);
        end
        cur_typed_en = 1'b0;

        // random part: fill, churn and drain bursts in three phases, the last without idling
        trend      = TREND_GROW;
        burst_left = $urandom_range(110, 60);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    trend      = trend_t'((int'(trend) + 1) % 3);
                    burst_left = $urandom_range(110, 60);
                end
                burst_left--;

                // operation, biased by the current trend, with a little noise
                r = $urandom_range(99);
                if ($urandom_range(99) < 4) begin
                    req.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
                end else begin
                    case (trend)
                        TREND_GROW: begin
                            if (r < 40) req.action = ACT_PUSH;
                            else if (r < 75) req.action = ACT_INSERT;
                            else if (r < 90) req.action = ACT_GET;
                            else if (r < 95) req.action = ACT_REMOVE;
                            else req.action = ACT_POP;
                        end
                        TREND_SHRINK: begin
                            if (r < 35) req.action = ACT_POP;
                            else if (r < 75) req.action = ACT_REMOVE;
                            else if (r < 90) req.action = ACT_GET;
                            else if (r < 95) req.action = ACT_PUSH;
                            else req.action = ACT_INSERT;
                        end
                        default: begin
                            if (r < 20) req.action = ACT_PUSH;
                            else if (r < 40) req.action = ACT_POP;
                            else if (r < 60) req.action = ACT_INSERT;
                            else if (r < 80) req.action = ACT_REMOVE;
                            else req.action = ACT_GET;
                        end
                    endcase
                end

                // position mostly inside the list, sometimes at the count or anywhere
                pos_pick = $urandom_range(99);
                if (pos_pick < 15) req.position = POS_W'($urandom_range(63));
                else if (pos_pick < 30) req.position = POS_W'((list_fill > 63) ? 63 : list_fill);
                else if (list_fill == 0) req.position = '0;
                else req.position = POS_W'($urandom_range(list_fill - 1));

                // word, with the extremes now and then
                r = $urandom_range(99);
                if (r < 10) req.item_value = '0;
                else if (r < 20) req.item_value = '1;
                else req.item_value = $urandom;

                send_item(req);
            end
        end
        s_valid <= 1'b0;

        // drain, then wait out stray results
        while (due_answers.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (due_answers.size() != 0)
            report_mismatch("results never arrived", due_answers.size(), 0);

        $display("ops seen: push %0d pop %0d insert %0d remove %0d get %0d unused %0d",
                 act_seen[ACT_PUSH], act_seen[ACT_POP], act_seen[ACT_INSERT],
                 act_seen[ACT_REMOVE], act_seen[ACT_GET],
                 act_seen[5] + act_seen[6] + act_seen[7]);
        $display("answers: %0d at full, %0d at empty, %0d out of range, %0d full rejects",
                 full_answers, empty_answers, range_answers, full_rejects);
        if (mismatch_count == 0) begin
            $display("ordered_list_shift_store_top regression: pass");
        end else begin
            $display("ordered_list_shift_store_top regression: fail");
        end
        $finish;
    end

endmodule
